FILE: design/tmcw_pkg.sv
// Package of shared types, constants and sizes for the text-mode console writer.
`default_nettype none

package tmcw_pkg;

  // Screen geometry.
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;

  // Field widths fixed by the interface.
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COORD_W = 8;
  localparam int IDX_W   = 11;
  localparam int LOC_W   = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  // Derived widths.
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int SUM_W  = (ADDR_W + 1 > IDX_W + 1) ? ADDR_W + 1 : IDX_W + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'b1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SETCUR = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_TAB,
    ST_WRAP,
    ST_WRITE,
    ST_SETTLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_SETC,
    ST_SETR,
    ST_READ,
    ST_RDREQ,
    ST_RDCAP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: design/text_mode_console_writer_unit.sv
// Top level of the text-mode console writer: sequencer, cursor, screen store.
// Throughput: one operation at a time; in_ready is high only while the sequencer idles.
// Reset: synchronous; a fill pass writes the reset blank to every cell while inputs wait.
// Configuration writes are taken in every cycle, during the fill pass as well.
`default_nettype none

module text_mode_console_writer_unit
  import tmcw_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  // Configuration write channel.
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [ATTR_W-1:0]     cfg_data,
  // Operation channel.
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [OP_W-1:0]       operation,
  input  wire [CHAR_W-1:0]     char_code,
  input  wire [COORD_W-1:0]    column,
  input  wire [COORD_W-1:0]    row,
  input  wire [IDX_W-1:0]      cell_index,
  // Result channel.
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [LOC_W-1:0]     cursor_location,
  output logic [CELL_W-1:0]    cell_value
);

  // The screen is kept as a ring of rows. top_base is the RAM address of the row shown
  // at the top, so a scroll moves top_base on by one row and blanks only the row that
  // drops off the top, which becomes the new bottom row.

  state_t              state, state_next;
  logic [COL_W-1:0]    cur_col, cur_col_next;
  logic [ROW_W-1:0]    cur_row, cur_row_next;
  logic [ADDR_W-1:0]   top_base, top_base_next;
  logic [SUM_W-1:0]    acc, acc_next;
  logic [ADDR_W-1:0]   cnt, cnt_next;
  op_t                 op_q, op_q_next;
  logic [CHAR_W-1:0]   ch_q, ch_q_next;
  logic [COORD_W-1:0]  row_q, row_q_next;
  logic [IDX_W-1:0]    idx_q, idx_q_next;
  logic [CELL_W-1:0]   cell_q, cell_q_next;
  logic [ATTR_W-1:0]   text_attr, blank_attr;
  logic                out_valid_next;
  logic [LOC_W-1:0]    cursor_location_next;
  logic [CELL_W-1:0]   cell_value_next;

  // Shared unit and RAM connections.
  logic [SUM_W-1:0]    su_a, su_b, su_diff;
  logic                su_ge;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [CELL_W-1:0]   wr_data;
  logic [CELL_W-1:0]   rd_data;

  // Helper terms.
  logic [SUM_W-1:0]    cur_lin;
  logic [ADDR_W:0]     base_step;
  logic [COL_W-1:0]    settle_col;
  logic [ROW_W-1:0]    settle_row;
  logic                printable;

  tmcw_csub u_csub (
    .a    (su_a),
    .b    (su_b),
    .ge   (su_ge),
    .diff (su_diff)
  );

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (acc[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  // Linear position of the cursor on the visible screen.
  assign cur_lin = SUM_W'(cur_row) * SUM_W'(COLUMNS) + SUM_W'(cur_col);

  // Next top-of-screen row base after a scroll; ST_SETTLE wraps it round the ring.
  assign base_step = {1'b0, top_base} + (ADDR_W + 1)'(COLUMNS);

  // Line wrap: a column past the right edge goes to the start of the next row.
  assign settle_col = (cur_col >= COL_W'(COLUMNS)) ? '0 : cur_col;
  assign settle_row = (cur_col >= COL_W'(COLUMNS)) ? cur_row + 1'b1 : cur_row;

  assign printable = (ch_q >= CH_SPACE) && (ch_q <= CH_PRINT_MAX);

  always_comb begin
    state_next           = state;
    cur_col_next         = cur_col;
    cur_row_next         = cur_row;
    top_base_next        = top_base;
    acc_next             = acc;
    cnt_next             = cnt;
    op_q_next            = op_q;
    ch_q_next            = ch_q;
    row_q_next           = row_q;
    idx_q_next           = idx_q;
    cell_q_next          = cell_q;
    out_valid_next       = out_valid & ~out_ready;
    cursor_location_next = cursor_location;
    cell_value_next      = cell_value;
    su_a                 = acc;
    su_b                 = SUM_W'(CELLS);
    wr_en                = 1'b0;
    wr_addr              = acc[ADDR_W-1:0];
    wr_data              = {blank_attr, CH_SPACE};

    unique case (state)
      ST_INIT: begin
        // Fill pass after reset: every cell gets the reset blank.
        wr_en    = 1'b1;
        wr_addr  = cnt;
        wr_data  = RESET_BLANK;
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_q_next   = op_t'(operation);
          ch_q_next   = char_code;
          row_q_next  = row;
          idx_q_next  = cell_index;
          cell_q_next = '0;
          unique case (op_t'(operation))
            OP_PUT: begin
              state_next = ST_PUT;
            end
            OP_CLEAR: begin
              cnt_next      = '0;
              top_base_next = '0;
              cur_col_next  = '0;
              cur_row_next  = '0;
              state_next    = ST_CLEAR;
            end
            OP_SETCUR: begin
              acc_next   = SUM_W'(column);
              state_next = ST_SETC;
            end
            OP_READ: begin
              state_next = ST_READ;
            end
          endcase
        end
      end

      ST_PUT: begin
        state_next = ST_SETTLE;
        priority if (ch_q == CH_BS) begin
          if (cur_col != '0) begin
            cur_col_next = cur_col - 1'b1;
          end
        end else if (ch_q == CH_TAB) begin
          acc_next   = SUM_W'(cur_col);
          state_next = ST_TAB;
        end else if (ch_q == CH_CR) begin
          cur_col_next = '0;
        end else if (ch_q == CH_LF) begin
          cur_col_next = '0;
          cur_row_next = cur_row + 1'b1;
        end else if (printable) begin
          acc_next   = cur_lin + SUM_W'(top_base);
          state_next = ST_WRAP;
        end else begin
          state_next = ST_SETTLE;
        end
      end

      ST_TAB: begin
        // Reduce the column modulo the tab stop, then step to the next stop.
        su_b = SUM_W'(TAB_STOP);
        if (su_ge) begin
          acc_next = su_diff;
        end else begin
          cur_col_next = cur_col - acc[COL_W-1:0] + COL_W'(TAB_STOP);
          state_next   = ST_SETTLE;
        end
      end

      ST_WRAP: begin
        // Fold a ring address back into the RAM range; one step is enough.
        su_b = SUM_W'(CELLS);
        if (su_ge) begin
          acc_next = su_diff;
        end
        state_next = (op_q == OP_PUT) ? ST_WRITE : ST_RDREQ;
      end

      ST_WRITE: begin
        wr_en        = 1'b1;
        wr_data      = {text_attr, ch_q};
        cur_col_next = cur_col + 1'b1;
        state_next   = ST_SETTLE;
      end

      ST_SETTLE: begin
        cur_col_next = settle_col;
        cur_row_next = settle_row;
        if (settle_row > ROW_W'(ROWS - 1)) begin
          cur_row_next  = ROW_W'(ROWS - 1);
          acc_next      = SUM_W'(top_base);
          cnt_next      = '0;
          top_base_next = (base_step == (ADDR_W + 1)'(CELLS)) ? '0
                                                              : base_step[ADDR_W-1:0];
          state_next    = ST_SCROLL;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_SCROLL: begin
        // Blank the row that has just become the bottom one.
        wr_en    = 1'b1;
        acc_next = acc + 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(COLUMNS - 1)) begin
          state_next = ST_DONE;
        end
      end

      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = cnt;
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end
      end

      ST_SETC: begin
        su_b = SUM_W'(COLUMNS);
        if (su_ge) begin
          acc_next = su_diff;
        end else begin
          cur_col_next = acc[COL_W-1:0];
          acc_next     = SUM_W'(row_q);
          state_next   = ST_SETR;
        end
      end

      ST_SETR: begin
        su_b = SUM_W'(ROWS);
        if (su_ge) begin
          acc_next = su_diff;
        end else begin
          cur_row_next = acc[ROW_W-1:0];
          state_next   = ST_DONE;
        end
      end

      ST_READ: begin
        // An index past the screen reads as zero.
        su_a = SUM_W'(idx_q);
        su_b = SUM_W'(CELLS);
        if (su_ge) begin
          state_next = ST_DONE;
        end else begin
          acc_next   = SUM_W'(idx_q) + SUM_W'(top_base);
          state_next = ST_WRAP;
        end
      end

      ST_RDREQ: begin
        state_next = ST_RDCAP;
      end

      ST_RDCAP: begin
        cell_q_next = rd_data;
        state_next  = ST_DONE;
      end

      ST_DONE: begin
        // Hold here until the output register is free.
        if (!out_valid || out_ready) begin
          out_valid_next       = 1'b1;
          cursor_location_next = cur_lin[LOC_W-1:0];
          cell_value_next      = (op_q == OP_READ) ? cell_q : '0;
          state_next           = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cur_col    <= '0;
      cur_row    <= '0;
      top_base   <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
      text_attr  <= RESET_ATTR;
      blank_attr <= RESET_ATTR;
    end else begin
      state     <= state_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      top_base  <= top_base_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TEXT_ATTR:  text_attr  <= cfg_data;
          REG_BLANK_ATTR: blank_attr <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc             <= acc_next;
    op_q            <= op_q_next;
    ch_q            <= ch_q_next;
    row_q           <= row_q_next;
    idx_q           <= idx_q_next;
    cell_q          <= cell_q_next;
    cursor_location <= cursor_location_next;
    cell_value      <= cell_value_next;
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cur_col < COL_W'(COLUMNS)) && (cur_row < ROW_W'(ROWS)))
    else $error("cursor out of range while idle");

  a_top_base_range: assert property (@(posedge clk) disable iff (rst)
    top_base < ADDR_W'(CELLS))
    else $error("top row base beyond screen store");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new transfer taken while an operation is in progress");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr < ADDR_W'(CELLS)))
    else $error("screen write address out of range");
`endif

endmodule

`default_nettype wire

FILE: design/tmcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire [WIDTH-1:0]          wr_data,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: design/tmcw_csub.sv
// Shared compare-and-subtract unit used for the modulo and address-fold steps and the read bound check.
`default_nettype none

module tmcw_csub
  import tmcw_pkg::*;
(
  input  wire  [SUM_W-1:0] a,
  input  wire  [SUM_W-1:0] b,
  output logic             ge,
  output logic [SUM_W-1:0] diff
);

  logic [SUM_W:0] full;

  // The borrow out of the subtraction doubles as the comparison.
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[SUM_W-1:0];
  assign ge   = ~full[SUM_W];

endmodule

`default_nettype wire

FILE: tb/sv/tb_text_mode_console_writer_unit.sv
// Self-checking testbench for the text-mode console writer: stimulus, prediction and checks.
module tb_text_mode_console_writer_unit;
  import tmcw_pkg::*;

  // One expected transfer on the result channel.
  typedef struct packed {
    logic [LOC_W-1:0]  loc;
    logic [CELL_W-1:0] cell_val;
  } console_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TEXT_ATTR;
  logic [ATTR_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  op_t                  operation = OP_PUT;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [COORD_W-1:0]   column = '0;
  logic [COORD_W-1:0]   row = '0;
  logic [IDX_W-1:0]     cell_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LOC_W-1:0]     cursor_location;
  logic [CELL_W-1:0]    cell_value;

  // Our own picture of the console: screen contents, cursor and the two attributes.
  logic [CELL_W-1:0] screen_copy [0:CELLS-1];
  int                cursor_col;
  int                cursor_row;
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] blank_attr;

  console_result_t pending_results [$];

  // When set, neither side of the block idles, giving a stretch at full rate.
  bit steady = 1'b0;

  int n_items;
  int n_results;
  int n_errors;
  int n_scrolls;
  int n_wraps;
  int n_clears;
  int n_reads;
  int n_settings;

  text_mode_console_writer_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .char_code       (char_code),
    .column          (column),
    .row             (row),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_location (cursor_location),
    .cell_value      (cell_value)
  );

  always #5 clk = ~clk;

  // The run is cut short here if the block stops making progress. The bound is several
  // times the slowest correct run, in which every operation would be a full-screen clear.
  initial begin
    #200_000_000;
    $display("Timeout at %0t with %0d results still outstanding", $time,
             pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // Result side. Each transfer is checked against the oldest expectation, using the
  // handshake values from just before the edge, and then a fresh ready is chosen.
  always @(posedge clk) begin
    console_result_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual loc %0d cell %h",
                 $time, cursor_location, cell_value);
      end else begin
        want = pending_results.pop_front();
        if (cursor_location !== want.loc) begin
          n_errors++;
          $display("%0t: cursor location mismatch, expected %0d actual %0d",
                   $time, want.loc, cursor_location);
        end
        if (cell_value !== want.cell_val) begin
          n_errors++;
          $display("%0t: cell value mismatch, expected %h actual %h",
                   $time, want.cell_val, cell_value);
        end
      end
    end
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 29);
  end

  function automatic logic [CELL_W-1:0] blank_cell();
    return {blank_attr, CH_SPACE};
  endfunction

  // Works out the result of one operation and advances our copy of the console.
  task automatic console_predict(input op_t op, input logic [CHAR_W-1:0] ch,
                                 input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw,
                                 input logic [IDX_W-1:0] idx);
    console_result_t r;
    int i;
    r.cell_val = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_BS) begin
          if (cursor_col != 0) cursor_col--;
        end else if (ch == CH_TAB) begin
          cursor_col = (cursor_col / TAB_STOP + 1) * TAB_STOP;
        end else if (ch == CH_CR) begin
          cursor_col = 0;
        end else if (ch == CH_LF) begin
          cursor_col = 0;
          cursor_row++;
        end else if (ch >= CH_SPACE && ch <= CH_PRINT_MAX) begin
          screen_copy[cursor_row * COLUMNS + cursor_col] = {text_attr, ch};
          cursor_col++;
        end
        // A column past the right edge wraps onto the next line.
        if (cursor_col >= COLUMNS) begin
          cursor_col = 0;
          cursor_row++;
          n_wraps++;
        end
        // Running off the bottom moves every row up and blanks the last one.
        if (cursor_row > ROWS - 1) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen_copy[i] = blank_cell();
          cursor_row = ROWS - 1;
          n_scrolls++;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_copy[i] = blank_cell();
        cursor_col = 0;
        cursor_row = 0;
        n_clears++;
      end
      OP_SETCUR: begin
        cursor_col = int'(col) % COLUMNS;
        cursor_row = int'(rw) % ROWS;
      end
      default: begin
        if (idx < CELLS) r.cell_val = screen_copy[idx];
        n_reads++;
      end
    endcase
    r.loc = LOC_W'(cursor_row * COLUMNS + cursor_col);
    pending_results.push_back(r);
  endtask

  // Presents one operation and waits for its transfer. Valid stays high into the next
  // operation unless a random gap is taken first.
  task automatic send_op(input op_t op, input logic [CHAR_W-1:0] ch,
                         input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw,
                         input logic [IDX_W-1:0] idx);
    if (!steady) begin
      while ($urandom_range(0, 99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    operation  <= op;
    char_code  <= ch;
    column     <= col;
    row        <= rw;
    cell_index <= idx;
    console_predict(op, ch, col, rw, idx);
    do @(posedge clk); while (!in_ready);
    n_items++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_op(OP_PUT, ch, 8'($urandom), 8'($urandom), 11'($urandom));
  endtask

  task automatic read_cell(input logic [IDX_W-1:0] idx);
    send_op(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), idx);
  endtask

  task automatic set_cursor(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw);
    send_op(OP_SETCUR, 8'($urandom), col, rw, 11'($urandom));
  endtask

  // Stops sending and waits until every outstanding result has been transferred.
  task automatic settle_console();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes both attribute registers back to back; the block must be idle.
  task automatic write_attributes(input logic [ATTR_W-1:0] text_val,
                                  input logic [ATTR_W-1:0] blank_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TEXT_ATTR;
    cfg_data  <= text_val;
    do @(posedge clk); while (!cfg_ready);
    text_attr = text_val;
    cfg_index <= REG_BLANK_ATTR;
    cfg_data  <= blank_val;
    do @(posedge clk); while (!cfg_ready);
    blank_attr = blank_val;
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // The store must come out of reset full of blanks, and reads past the end give zero.
  task automatic test_reset_screen();
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
  endtask

  // Printable bytes at both ends of the range are stored; bytes outside it are ignored.
  task automatic test_printable_and_ignored();
    put_char(8'h41);
    put_char(CH_SPACE);
    put_char(CH_PRINT_MAX);
    put_char(8'h00);
    put_char(8'h1F);
    put_char(8'h80);
    put_char(8'hFF);
    read_cell(11'd0);
    read_cell(11'd2);
  endtask

  // Backspace in the middle and at column zero, carriage return, tabs and line feed.
  task automatic test_control_codes();
    put_char(CH_BS);
    put_char(CH_CR);
    put_char(CH_BS);
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_LF);
  endtask

  // Cursor setting with out-of-range coordinates, then wrap and scroll from the last cell,
  // from a tab near the right edge and from a line feed on the bottom row, then a clear.
  task automatic test_wrap_and_scroll();
    set_cursor(8'hFF, 8'hFF);
    set_cursor(8'(COLUMNS - 1), 8'(ROWS - 1));
    put_char(8'h5A);
    read_cell(11'(CELLS - COLUMNS - 1));
    read_cell(11'(CELLS - COLUMNS));
    set_cursor(8'(COLUMNS - 2), 8'(ROWS - 1));
    put_char(CH_TAB);
    put_char(CH_LF);
    send_op(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 11'($urandom));
    read_cell(11'd0);
  endtask

  // Builds one random operation. Most are characters, mostly printable, with up to half of
  // the reads aimed near the cursor so that freshly written and scrolled cells are looked at.
  task automatic random_op();
    int pick;
    int sel;
    int near;
    logic [CHAR_W-1:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        ch = 8'($urandom_range(int'(CH_SPACE), int'(CH_PRINT_MAX)));
      end else if (sel < 90) begin
        case ($urandom_range(0, 3))
          0: ch = CH_BS;
          1: ch = CH_TAB;
          2: ch = CH_CR;
          default: ch = CH_LF;
        endcase
      end else begin
        ch = 8'($urandom);
      end
      put_char(ch);
    end else if (pick < 70) begin
      // Half of the cursor moves land near the bottom right to provoke wraps and scrolls.
      if ($urandom_range(0, 1))
        set_cursor(8'($urandom), 8'($urandom));
      else
        set_cursor(8'(COLUMNS * $urandom_range(0, 2) + $urandom_range(COLUMNS - 20, COLUMNS - 1)),
                   8'(ROWS * $urandom_range(0, 9) + ROWS - 1));
    end else if (pick < 98) begin
      near = cursor_row * COLUMNS + cursor_col - $urandom_range(0, 2 * COLUMNS);
      if (near < 0 || $urandom_range(0, 1)) read_cell(11'($urandom));
      else read_cell(11'(near));
    end else begin
      send_op(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 11'($urandom));
    end
  endtask

  // Random traffic in phases, each under its own attribute setting. The block is drained
  // before every register write, so the sender also pauses for all results at that point.
  task automatic test_random();
    logic [ATTR_W-1:0] text_list [6];
    logic [ATTR_W-1:0] blank_list [6];
    int phase;
    text_list  = '{8'hFF, 8'h00, 8'($urandom), RESET_ATTR, 8'($urandom), 8'hA5};
    blank_list = '{8'h00, 8'hFF, 8'($urandom), RESET_ATTR, 8'($urandom), 8'h5A};
    for (phase = 0; phase < 6; phase++) begin
      settle_console();
      write_attributes(text_list[phase], blank_list[phase]);
      steady = (phase == 2);
      repeat (200) random_op();
    end
    steady = 1'b0;
  endtask

  initial begin
    int i;
    text_attr  = RESET_ATTR;
    blank_attr = RESET_ATTR;
    for (i = 0; i < CELLS; i++) screen_copy[i] = RESET_BLANK;
    cursor_col = 0;
    cursor_row = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The first transfer is held off by the block until its clearing pass has finished.
    test_reset_screen();
    test_printable_and_ignored();
    test_control_codes();
    test_wrap_and_scroll();
    test_random();

    settle_console();
    // Wait a while with nothing sent so that any stray extra transfer is caught.
    repeat (200) @(posedge clk);

    $display("Ran %0d operations under %0d attribute settings and checked %0d results.",
             n_items, n_settings + 1, n_results);
    $display("Seen: %0d scrolls, %0d wraps, %0d clears, %0d cell reads, %0d errors.",
             n_scrolls, n_wraps, n_clears, n_reads, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tmcw_pkg.sv
design/tmcw_ram.sv
design/tmcw_csub.sv
design/text_mode_console_writer_unit.sv
tb/sv/tb_text_mode_console_writer_unit.sv
